// ===== rtl/bsgc_pkg.sv =====
// Shared constants, state type and helper function for the bitmap core.
// Used by bitmap_set_get_count_core; no dependencies.
package bsgc_pkg;

    localparam int BYTE_CAPACITY = 4096;
    localparam int GROW_SHIFT    = 4;
    localparam int GROW_STEP     = 1 << GROW_SHIFT;

    localparam int OP_W     = 2;
    localparam int OFFSET_W = 15;
    localparam int RANGE_W  = 13;
    localparam int COUNT_W  = 16;

    localparam int ADDR_W = $clog2(BYTE_CAPACITY);
    localparam int LEN_W  = $clog2(BYTE_CAPACITY + 1);
    localparam int ACC_W  = $clog2(BYTE_CAPACITY * 8 + 1);
    // wide signed scratch width for index and range arithmetic
    localparam int WIDE_W = 18;

    localparam logic [OP_W-1:0] OP_SET   = 2'd0;
    localparam logic [OP_W-1:0] OP_GET   = 2'd1;
    localparam logic [OP_W-1:0] OP_COUNT = 2'd2;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_ACC   = 6'b000100,
        ST_WALK  = 6'b001000,
        ST_DRAIN = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    function automatic logic [3:0] byte_ones(input logic [7:0] v);
        logic [7:0] t;
        begin
            t = v - ((v >> 1) & 8'h55);
            t = (t & 8'h33) + ((t >> 2) & 8'h33);
            t = (t + (t >> 4)) & 8'h0F;
            byte_ones = t[3:0];
        end
    endfunction

endpackage

// ===== rtl/bsgc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bsgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bitmap_set_get_count_core.sv =====
// Growable byte bitmap with set, get and range population count.
// Depends on bsgc_pkg and bsgc_ram.
//
// Usage:
//   Input channel s_*: operation (set/get/count), bit offset (msb-first within
//   each byte), value for set, and a signed inclusive byte range for count
//   (negative indices count back from the current length, then clamp).
//   Result channel m_*: one result per input transfer: old/current bit,
//   population count, and an overflow flag for a set beyond capacity.
// Timing:
//   After reset the byte store is swept to zero, one byte per cycle, with
//   s_ready low. Length resets to zero. Set and get read the byte when the
//   item is taken, then deliver the result and, for set only, write the
//   byte back on the single RAM. Get past the length, overflow and empty
//   ranges go straight to the final step. Count walks the clamped range,
//   one RAM read per byte, then drains before the final step.
//   A finished result sits in the output register; the next item is taken
//   while it waits. If the receiver stalls, the core holds at its final
//   step until the output register frees up.
module bitmap_set_get_count_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [bsgc_pkg::OP_W-1:0]            s_operation,
    input  logic [bsgc_pkg::OFFSET_W-1:0]        s_bit_offset,
    input  logic                                 s_bit_value,
    input  logic signed [bsgc_pkg::RANGE_W-1:0]  s_range_start,
    input  logic signed [bsgc_pkg::RANGE_W-1:0]  s_range_end,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_bit_result,
    output logic [bsgc_pkg::COUNT_W-1:0]         m_bit_count,
    output logic                                 m_overflow_error
);

    import bsgc_pkg::*;

    state_t              state_reg, state_next;
    logic [LEN_W-1:0]    used_len_reg, used_len_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [ADDR_W-1:0]   rd_addr_reg, rd_addr_next;
    logic [ADDR_W-1:0]   end_reg, end_next;
    logic [2:0]          bsel_reg, bsel_next;
    logic                val_reg, val_next;
    logic                is_set_reg, is_set_next;
    logic                pend_reg, pend_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic                res_bit_reg, res_bit_next;
    logic                err_reg, err_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_bit_result_reg, m_bit_result_next;
    logic [COUNT_W-1:0]  m_bit_count_reg, m_bit_count_next;
    logic                m_err_reg, m_err_next;

    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [7:0]          ram_wdata, ram_rdata;

    // byte index of the incoming offset, and range adjustment
    logic [WIDE_W-1:0]        idx_w, need_w, grown_w;
    logic [ADDR_W-1:0]        in_addr;
    logic signed [WIDE_W-1:0] len_s, rng_s, rng_e;
    logic                     rng_empty;
    logic                     out_space;
    logic [7:0]               mod_byte;
    logic [ACC_W+COUNT_W-1:0] acc_ext;

    bsgc_ram #(
        .WIDTH (8),
        .DEPTH (BYTE_CAPACITY)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        idx_w   = WIDE_W'(s_bit_offset[OFFSET_W-1:3]);
        in_addr = idx_w[ADDR_W-1:0];
        need_w  = idx_w + WIDE_W'(1);
        grown_w = (need_w + WIDE_W'(GROW_STEP - 1)) & ~WIDE_W'(GROW_STEP - 1);
        if (grown_w > WIDE_W'(BYTE_CAPACITY)) begin
            grown_w = WIDE_W'(BYTE_CAPACITY);
        end
    end

    always_comb begin
        len_s = WIDE_W'(used_len_reg);
        rng_s = {{(WIDE_W-RANGE_W){s_range_start[RANGE_W-1]}}, s_range_start};
        rng_e = {{(WIDE_W-RANGE_W){s_range_end[RANGE_W-1]}}, s_range_end};
        if (rng_s < 0) begin
            rng_s = rng_s + len_s;
        end
        if (rng_e < 0) begin
            rng_e = rng_e + len_s;
        end
        if (rng_s < 0) begin
            rng_s = '0;
        end
        if (rng_e < 0) begin
            rng_e = '0;
        end
        if (rng_e >= len_s) begin
            rng_e = len_s - WIDE_W'(1);
        end
        rng_empty = (used_len_reg == '0) || (rng_s > rng_e);
    end

    assign out_space = !m_valid_reg || m_ready;
    assign acc_ext   = {{COUNT_W{1'b0}}, acc_reg};

    always_comb begin
        mod_byte           = ram_rdata;
        mod_byte[bsel_reg] = val_reg;
    end

    always_comb begin
        state_next        = state_reg;
        used_len_next     = used_len_reg;
        clr_next          = clr_reg;
        rd_addr_next      = rd_addr_reg;
        end_next          = end_reg;
        bsel_next         = bsel_reg;
        val_next          = val_reg;
        is_set_next       = is_set_reg;
        pend_next         = pend_reg;
        acc_next          = acc_reg;
        res_bit_next      = res_bit_reg;
        err_next          = err_reg;
        m_valid_next      = m_valid_reg;
        m_bit_result_next = m_bit_result_reg;
        m_bit_count_next  = m_bit_count_reg;
        m_err_next        = m_err_reg;
        ram_we            = 1'b0;
        ram_waddr         = rd_addr_reg;
        ram_wdata         = mod_byte;
        ram_re            = 1'b0;
        ram_raddr         = rd_addr_reg;
        s_ready           = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(BYTE_CAPACITY - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready   = 1'b1;
                ram_re    = s_valid;
                ram_raddr = in_addr;
                if (s_valid) begin
                    res_bit_next = 1'b0;
                    acc_next     = '0;
                    err_next     = 1'b0;
                    pend_next    = 1'b0;
                    bsel_next    = ~s_bit_offset[2:0];
                    val_next     = s_bit_value;
                    is_set_next  = (s_operation == OP_SET);
                    rd_addr_next = in_addr;
                    priority if (s_operation == OP_SET) begin
                        if (idx_w >= WIDE_W'(BYTE_CAPACITY)) begin
                            err_next   = 1'b1;
                            state_next = ST_FIN;
                        end else begin
                            if (idx_w >= WIDE_W'(used_len_reg)) begin
                                used_len_next = grown_w[LEN_W-1:0];
                            end
                            state_next = ST_ACC;
                        end
                    end else if (s_operation == OP_GET) begin
                        if (idx_w < WIDE_W'(used_len_reg)) begin
                            state_next = ST_ACC;
                        end else begin
                            state_next = ST_FIN;
                        end
                    end else if (s_operation == OP_COUNT) begin
                        if (rng_empty) begin
                            state_next = ST_FIN;
                        end else begin
                            rd_addr_next = rng_s[ADDR_W-1:0];
                            end_next     = rng_e[ADDR_W-1:0];
                            state_next   = ST_WALK;
                        end
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_ACC: begin
                // read data holds while stalled: no new read is issued here
                if (out_space) begin
                    m_valid_next      = 1'b1;
                    m_bit_result_next = ram_rdata[bsel_reg];
                    m_bit_count_next  = '0;
                    m_err_next        = 1'b0;
                    ram_we            = is_set_reg;
                    state_next        = ST_IDLE;
                end
            end
            ST_WALK: begin
                ram_re       = 1'b1;
                pend_next    = 1'b1;
                rd_addr_next = rd_addr_reg + ADDR_W'(1);
                if (pend_reg) begin
                    acc_next = acc_reg + ACC_W'(byte_ones(ram_rdata));
                end
                if (rd_addr_reg == end_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                acc_next   = acc_reg + ACC_W'(byte_ones(ram_rdata));
                pend_next  = 1'b0;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_space) begin
                    m_valid_next      = 1'b1;
                    m_bit_result_next = res_bit_reg;
                    m_bit_count_next  = acc_ext[COUNT_W-1:0];
                    m_err_next        = err_reg;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            used_len_reg <= '0;
            clr_reg      <= '0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            used_len_reg <= used_len_next;
            clr_reg      <= clr_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg      <= rd_addr_next;
        end_reg          <= end_next;
        bsel_reg         <= bsel_next;
        val_reg          <= val_next;
        is_set_reg       <= is_set_next;
        acc_reg          <= acc_next;
        res_bit_reg      <= res_bit_next;
        err_reg          <= err_next;
        m_bit_result_reg <= m_bit_result_next;
        m_bit_count_reg  <= m_bit_count_next;
        m_err_reg        <= m_err_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_bit_result     = m_bit_result_reg;
    assign m_bit_count      = m_bit_count_reg;
    assign m_overflow_error = m_err_reg;

endmodule
